@@ design/serial_command_timed_motor_driver_assert.svh @@
// Assertion macros used by the motor driver RTL.
`ifndef SERIAL_COMMAND_TIMED_MOTOR_DRIVER_ASSERT_SVH
`define SERIAL_COMMAND_TIMED_MOTOR_DRIVER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is held.
`define SCMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SCMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCMD_ASSERT(lbl, prop, msg)
`define SCMD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ design/scmd_pkg.sv @@
// Types, constants and helper functions for the serial command motor driver.
`default_nettype none
package scmd_pkg;

  localparam int LINE_CAPACITY_DEF = 100;

  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 10;
  localparam int MS_W     = 16;
  localparam int MA_W     = 8;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  localparam logic [MS_W-1:0] OPEN_RUN_RST   = 16'd3000;
  localparam logic [MS_W-1:0] CLOSE_RUN_RST  = 16'd6000;
  localparam logic [MS_W-1:0] PERIOD_RST     = 16'd1000;
  localparam logic [MS_W-1:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [MA_W-1:0] CURRENT_MAX    = 8'd200;

  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

  localparam int OPEN_LEN  = 4;
  localparam int CLOSE_LEN = 5;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_OPEN_RUN  = 2'd0;
  localparam logic [1:0] REG_CLOSE_RUN = 2'd1;
  localparam logic [1:0] REG_PERIOD    = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic            motor_on;
    logic            motor_reverse;
    cmd_t            command_seen;
    logic            report_valid;
    logic [MA_W-1:0] sense_ma;
    logic            led_level;
  } res_t;

  function automatic logic [BYTE_W-1:0] open_char(input logic [2:0] p);
    logic [BYTE_W-1:0] c;
    case (p)
      3'd0:    c = 8'h4F; // O
      3'd1:    c = 8'h50; // P
      3'd2:    c = 8'h45; // E
      3'd3:    c = 8'h4E; // N
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] close_char(input logic [2:0] p);
    logic [BYTE_W-1:0] c;
    case (p)
      3'd0:    c = 8'h43; // C
      3'd1:    c = 8'h4C; // L
      3'd2:    c = 8'h4F; // O
      3'd3:    c = 8'h53; // S
      3'd4:    c = 8'h45; // E
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // floor(s*5000/1023/25) == floor(s*200/1023); the divide by 1023 uses
  // (y + (y >> 10) + 1) >> 10, exact while the quotient stays below 1024
  function automatic logic [MA_W-1:0] sample_to_ma(input logic [SAMPLE_W-1:0] s);
    logic [17:0] y;
    logic [17:0] t;
    y = 18'(s) * 18'd200;
    t = y + (y >> 10) + 18'd1;
    return MA_W'(t >> 10);
  endfunction

endpackage
`default_nettype wire

@@ design/scmd_in_if.sv @@
// Input channel: serial byte or millisecond tick, with valid/ready.
`default_nettype none
interface scmd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [scmd_pkg::BYTE_W-1:0]   rx_byte;
  logic [scmd_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, opcode, rx_byte, adc_sample, input ready);
  modport sink   (input valid, opcode, rx_byte, adc_sample, output ready);
endinterface
`default_nettype wire

@@ design/scmd_out_if.sv @@
// Result channel: motor, command, report and LED levels, with valid/ready.
`default_nettype none
interface scmd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      motor_on;
  logic                      motor_reverse;
  logic [1:0]                command_seen;
  logic                      report_valid;
  logic [scmd_pkg::MA_W-1:0] sense_ma;
  logic                      led_level;

  modport source (output valid, motor_on, motor_reverse, command_seen, report_valid,
                  sense_ma, led_level, input ready);
  modport sink   (input valid, motor_on, motor_reverse, command_seen, report_valid,
                  sense_ma, led_level, output ready);
endinterface
`default_nettype wire

@@ design/serial_command_timed_motor_driver.sv @@
// Serial command timed motor driver: one input register, one result register.
// Flow: an accepted item waits in the input register and its result is registered as it
// advances; a full result register without out_ch.ready stalls the input register.
// Throughput: one item per cycle unless stalled; input ready follows output ready.
// Reset: synchronous, active low; clears valid flags and block state and loads register defaults.
`default_nettype none
`include "serial_command_timed_motor_driver_assert.svh"
module serial_command_timed_motor_driver #(
  parameter int LINE_CAPACITY = scmd_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  scmd_in_if.sink                          in_ch,
  scmd_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [scmd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [scmd_pkg::DATA_W-1:0] pwdata,
  output logic      [scmd_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int MS_W = scmd_pkg::MS_W;

  // configuration
  logic [MS_W-1:0] open_run_r, close_run_r, period_r;
  logic            cfg_wr;

  // input register
  logic                          s1_valid_r;
  logic                          s1_op_r;
  logic [scmd_pkg::BYTE_W-1:0]   s1_byte_r;
  logic [scmd_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic                          s1_adv;
  logic                          in_xfer;

  // block state
  logic            motor_active_r, motor_active_nxt;
  logic            dir_r, dir_nxt;
  logic [MS_W-1:0] run_limit_r, run_limit_nxt;
  logic [MS_W-1:0] elapsed_r, elapsed_nxt;
  logic [MS_W-1:0] report_cnt_r, report_cnt_nxt;
  logic            led_r, led_nxt;

  // result register
  logic           out_valid_r;
  scmd_pkg::res_t out_r, res;

  scmd_pkg::cmd_t cmd;
  logic           tick;
  logic           rpt;
  logic           act_a;
  logic [MS_W-1:0] cnt_inc;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_run_r  <= scmd_pkg::OPEN_RUN_RST;
      close_run_r <= scmd_pkg::CLOSE_RUN_RST;
      period_r    <= scmd_pkg::PERIOD_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        scmd_pkg::REG_OPEN_RUN:  open_run_r  <= pwdata[MS_W-1:0];
        scmd_pkg::REG_CLOSE_RUN: close_run_r <= pwdata[MS_W-1:0];
        scmd_pkg::REG_PERIOD:    period_r    <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      scmd_pkg::REG_OPEN_RUN:  prdata = scmd_pkg::DATA_W'(open_run_r);
      scmd_pkg::REG_CLOSE_RUN: prdata = scmd_pkg::DATA_W'(close_run_r);
      scmd_pkg::REG_PERIOD:    prdata = scmd_pkg::DATA_W'(period_r);
      default:                 prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r     <= in_ch.opcode;
      s1_byte_r   <= in_ch.rx_byte;
      s1_sample_r <= in_ch.adc_sample;
    end
  end

  // ---------------- item processing ----------------
  assign tick = (s1_op_r == scmd_pkg::OP_TICK);

  scmd_line #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (s1_adv && !tick),
    .rx_byte (s1_byte_r),
    .cmd     (cmd)
  );

  // report counter saturates; a zero period reports on every tick
  assign cnt_inc = (report_cnt_r == scmd_pkg::COUNT_MAX) ? report_cnt_r
                                                         : report_cnt_r + MS_W'(1);
  assign rpt     = tick && (cnt_inc >= period_r);

  always_comb begin
    act_a          = motor_active_r;
    dir_nxt        = dir_r;
    run_limit_nxt  = run_limit_r;
    elapsed_nxt    = elapsed_r;
    report_cnt_nxt = report_cnt_r;
    led_nxt        = led_r;
    if (cmd == scmd_pkg::CMD_OPEN) begin
      act_a         = 1'b1;
      dir_nxt       = 1'b0;
      run_limit_nxt = open_run_r;
      elapsed_nxt   = '0;
    end else if (cmd == scmd_pkg::CMD_CLOSE) begin
      act_a         = 1'b1;
      dir_nxt       = 1'b1;
      run_limit_nxt = close_run_r;
      elapsed_nxt   = '0;
    end else if (tick) begin
      if (motor_active_r && (elapsed_r < run_limit_r)) begin
        elapsed_nxt = elapsed_r + MS_W'(1);
      end
      report_cnt_nxt = rpt ? '0 : cnt_inc;
      led_nxt        = rpt ? !led_r : led_r;
    end
    // stop check at the end of every item, also for a zero run time
    motor_active_nxt = act_a && (elapsed_nxt < run_limit_nxt);

    res.motor_on      = motor_active_nxt;
    res.motor_reverse = dir_nxt;
    res.command_seen  = cmd;
    res.report_valid  = rpt;
    res.sense_ma      = rpt ? scmd_pkg::sample_to_ma(s1_sample_r) : '0;
    res.led_level     = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_active_r <= 1'b0;
      dir_r          <= 1'b0;
      run_limit_r    <= '0;
      elapsed_r      <= '0;
      report_cnt_r   <= '0;
      led_r          <= 1'b0;
    end else if (s1_adv) begin
      motor_active_r <= motor_active_nxt;
      dir_r          <= dir_nxt;
      run_limit_r    <= run_limit_nxt;
      elapsed_r      <= elapsed_nxt;
      report_cnt_r   <= report_cnt_nxt;
      led_r          <= led_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.motor_on      = out_r.motor_on;
  assign out_ch.motor_reverse = out_r.motor_reverse;
  assign out_ch.command_seen  = out_r.command_seen;
  assign out_ch.report_valid  = out_r.report_valid;
  assign out_ch.sense_ma      = out_r.sense_ma;
  assign out_ch.led_level     = out_r.led_level;

  // ---------------- checks ----------------
  `SCMD_ASSERT_ALWAYS(a_run_below_limit, motor_active_r |-> (elapsed_r < run_limit_r),
                      "motor running at or past its limit")
  `SCMD_ASSERT(a_led_toggles, (s1_adv && rpt) |=> (led_r != $past(led_r)),
               "LED did not toggle on report")
  `SCMD_ASSERT(a_open_forward,
               (out_valid_r && (out_r.command_seen == scmd_pkg::CMD_OPEN)) |->
               !out_r.motor_reverse, "OPEN result shows reverse")
  `SCMD_ASSERT(a_quiet_current,
               (out_valid_r && !out_r.report_valid) |-> (out_r.sense_ma == '0),
               "current without report")
  `SCMD_ASSERT(a_current_range,
               out_valid_r |-> (out_r.sense_ma <= scmd_pkg::CURRENT_MAX),
               "current out of range")

endmodule
`default_nettype wire

@@ design/scmd_line.sv @@
// Line assembler: tracks length and OPEN/CLOSE prefix match, decodes on CR/LF.
`default_nettype none
module scmd_line #(
  parameter int LINE_CAPACITY = scmd_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        byte_en,
  input  wire logic [scmd_pkg::BYTE_W-1:0] rx_byte,
  output scmd_pkg::cmd_t                   cmd
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             open_ok_r, open_ok_nxt;
  logic             close_ok_r, close_ok_nxt;
  logic             eol;
  logic             open_hit, close_hit;

  assign eol = (rx_byte == scmd_pkg::CHAR_LF) || (rx_byte == scmd_pkg::CHAR_CR);

  assign open_hit  = (len_r < LEN_W'(scmd_pkg::OPEN_LEN)) &&
                     (rx_byte == scmd_pkg::open_char(len_r[2:0]));
  assign close_hit = (len_r < LEN_W'(scmd_pkg::CLOSE_LEN)) &&
                     (rx_byte == scmd_pkg::close_char(len_r[2:0]));

  always_comb begin
    len_nxt      = len_r;
    open_ok_nxt  = open_ok_r;
    close_ok_nxt = close_ok_r;
    cmd          = scmd_pkg::CMD_NONE;
    if (byte_en) begin
      if (eol) begin
        if ((len_r == LEN_W'(scmd_pkg::OPEN_LEN)) && open_ok_r) begin
          cmd = scmd_pkg::CMD_OPEN;
        end else if ((len_r == LEN_W'(scmd_pkg::CLOSE_LEN)) && close_ok_r) begin
          cmd = scmd_pkg::CMD_CLOSE;
        end
        len_nxt      = '0;
        open_ok_nxt  = 1'b1;
        close_ok_nxt = 1'b1;
      end else if (len_r < LEN_W'(LINE_CAPACITY - 1)) begin
        // characters past a full line are dropped
        open_ok_nxt  = open_ok_r && open_hit;
        close_ok_nxt = close_ok_r && close_hit;
        len_nxt      = len_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      open_ok_r  <= 1'b1;
      close_ok_r <= 1'b1;
    end else begin
      len_r      <= len_nxt;
      open_ok_r  <= open_ok_nxt;
      close_ok_r <= close_ok_nxt;
    end
  end

endmodule
`default_nettype wire

@@ test/serial_command_timed_motor_driver_test.sv @@
// Self-checking testbench for the serial command timed motor driver.
`default_nettype none
module serial_command_timed_motor_driver_test;

  localparam int MS_W = scmd_pkg::MS_W;
  localparam int QUIET_LIMIT = 1000;
  localparam int LINE_LIMIT = scmd_pkg::LINE_CAPACITY_DEF - 1;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [31:0] OPEN_TXT = "OPEN";
  localparam logic [39:0] CLOSE_TXT = "CLOSE";

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [scmd_pkg::ADDR_W-1:0] paddr;
  logic [scmd_pkg::DATA_W-1:0] pwdata;
  logic [scmd_pkg::DATA_W-1:0] prdata;
  logic pready;

  scmd_in_if in_bus ();
  scmd_out_if out_bus ();

  serial_command_timed_motor_driver DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // predicted block state and register copies
  logic [MS_W-1:0] open_run_cfg;
  logic [MS_W-1:0] close_run_cfg;
  logic [MS_W-1:0] period_cfg;
  logic [6:0] line_len;
  logic open_ok;
  logic close_ok;
  logic running;
  logic run_reverse;
  logic [MS_W-1:0] run_limit;
  logic [MS_W-1:0] elapsed;
  logic [MS_W-1:0] report_count;
  logic led;

  scmd_pkg::res_t pending_levels[$];
  scmd_pkg::res_t want_levels;
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic void start_run(input logic rev, input logic [MS_W-1:0] limit);
    running = 1'b1;
    run_reverse = rev;
    run_limit = limit;
    elapsed = '0;
  endfunction

  function automatic scmd_pkg::res_t next_drive_levels(input scmd_pkg::op_t op,
                                                       input logic [7:0] ch,
                                                       input logic [9:0] sample);
    scmd_pkg::res_t lv;
    int pos;
    lv = '0;
    lv.command_seen = scmd_pkg::CMD_NONE;
    pos = int'(line_len);
    if (op == scmd_pkg::OP_BYTE) begin
      if (ch == scmd_pkg::CHAR_LF || ch == scmd_pkg::CHAR_CR) begin
        if (pos == scmd_pkg::OPEN_LEN && open_ok) begin
          start_run(1'b0, open_run_cfg);
          lv.command_seen = scmd_pkg::CMD_OPEN;
        end else if (pos == scmd_pkg::CLOSE_LEN && close_ok) begin
          start_run(1'b1, close_run_cfg);
          lv.command_seen = scmd_pkg::CMD_CLOSE;
        end
        line_len = '0;
        open_ok = 1'b1;
        close_ok = 1'b1;
      end else if (pos < LINE_LIMIT) begin
        if (!(pos < scmd_pkg::OPEN_LEN && ch == OPEN_TXT[31-8*pos -: 8])) open_ok = 1'b0;
        if (!(pos < scmd_pkg::CLOSE_LEN && ch == CLOSE_TXT[39-8*pos -: 8])) close_ok = 1'b0;
        line_len = line_len + 7'd1;
      end
    end else begin
      if (running && elapsed < run_limit) elapsed = elapsed + 16'd1;
      if (report_count != scmd_pkg::COUNT_MAX) report_count = report_count + 16'd1;
      // period 0 behaves as 1, since the count is at least 1 here
      if (report_count >= period_cfg) begin
        report_count = '0;
        led = ~led;
        lv.report_valid = 1'b1;
        lv.sense_ma = 8'(int'(sample) * 5000 / 1023 / 25);
      end
    end
    if (running && elapsed >= run_limit) running = 1'b0;
    lv.motor_on = running;
    lv.motor_reverse = run_reverse;
    lv.led_level = led;
    return lv;
  endfunction

  function automatic void reset_prediction();
    open_run_cfg = scmd_pkg::OPEN_RUN_RST;
    close_run_cfg = scmd_pkg::CLOSE_RUN_RST;
    period_cfg = scmd_pkg::PERIOD_RST;
    line_len = '0;
    open_ok = 1'b1;
    close_ok = 1'b1;
    running = 1'b0;
    run_reverse = 1'b0;
    run_limit = '0;
    elapsed = '0;
    report_count = '0;
    led = 1'b0;
  endfunction

  function automatic logic [9:0] rand_sample();
    return 10'($urandom_range(1023));
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] ch;
    ch = 8'($urandom);
    while (ch == scmd_pkg::CHAR_CR || ch == scmd_pkg::CHAR_LF) ch = 8'($urandom);
    return ch;
  endfunction

  function automatic logic [7:0] rand_terminator();
    return ($urandom_range(1) == 0) ? scmd_pkg::CHAR_CR : scmd_pkg::CHAR_LF;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got,
             want);
    mismatches++;
  endtask

  // one item on the input channel; valid stays high after the transfer
  task automatic send_item(input scmd_pkg::op_t op, input logic [7:0] ch,
                           input logic [9:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      in_bus.opcode <= 1'($urandom);
      in_bus.rx_byte <= 8'($urandom);
      in_bus.adc_sample <= rand_sample();
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.opcode <= op;
    in_bus.rx_byte <= ch;
    in_bus.adc_sample <= sample;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pending_levels.push_back(next_drive_levels(op, ch, sample));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(scmd_pkg::OP_BYTE, s[i], rand_sample());
  endtask

  task automatic send_line(input string s, input logic [7:0] term);
    send_text(s);
    send_item(scmd_pkg::OP_BYTE, term, rand_sample());
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(scmd_pkg::OP_TICK, 8'($urandom), rand_sample());
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      scmd_pkg::REG_OPEN_RUN: open_run_cfg = value;
      scmd_pkg::REG_CLOSE_RUN: close_run_cfg = value;
      scmd_pkg::REG_PERIOD: period_cfg = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] open_ms, input logic [15:0] close_ms,
                           input logic [15:0] period);
    drain_results();
    write_reg(scmd_pkg::REG_OPEN_RUN, open_ms);
    write_reg(scmd_pkg::REG_CLOSE_RUN, close_ms);
    write_reg(scmd_pkg::REG_PERIOD, period);
  endtask

  // command word with one letter dropped, replaced or one added
  task automatic send_near_miss();
    string w;
    int k;
    int mode;
    if ($urandom_range(1) == 0) w = "OPEN";
    else w = "CLOSE";
    k = $urandom_range(w.len() - 1);
    mode = $urandom_range(2);
    for (int i = 0; i < w.len(); i++) begin
      if (mode == 1 && i == k) send_item(scmd_pkg::OP_BYTE, 8'($urandom), rand_sample());
      else if (!(mode == 0 && i == k)) send_item(scmd_pkg::OP_BYTE, w[i], rand_sample());
    end
    if (mode == 2) send_item(scmd_pkg::OP_BYTE, 8'($urandom), rand_sample());
    send_item(scmd_pkg::OP_BYTE, rand_terminator(), rand_sample());
  endtask

  task automatic test_commands();
    send_line("OPEN", scmd_pkg::CHAR_CR);
    send_item(scmd_pkg::OP_TICK, 8'h00, 10'd0);
    send_item(scmd_pkg::OP_TICK, 8'hFF, 10'd1023);
    send_item(scmd_pkg::OP_TICK, 8'h55, 10'h2AA);
    send_line("CLOSE", scmd_pkg::CHAR_LF);
    send_item(scmd_pkg::OP_BYTE, scmd_pkg::CHAR_LF, rand_sample());
    // NUL counts as a character, so this line is five long
    send_text("OPEN");
    send_item(scmd_pkg::OP_BYTE, 8'h00, rand_sample());
    send_item(scmd_pkg::OP_BYTE, scmd_pkg::CHAR_LF, rand_sample());
    send_line("CLOS", scmd_pkg::CHAR_CR);
  endtask

  task automatic test_zero_settings();
    configure(16'd0, 16'd0, 16'd0);
    send_line("OPEN", scmd_pkg::CHAR_LF);
    send_item(scmd_pkg::OP_TICK, 8'h00, 10'd1023);
    send_item(scmd_pkg::OP_TICK, 8'hFF, 10'd0);
    send_item(scmd_pkg::OP_TICK, 8'h00, 10'd511);
    send_line("CLOSE", scmd_pkg::CHAR_CR);
    send_ticks(2);
  endtask

  task automatic test_run_time_change();
    configure(16'd5, 16'd7, 16'd3);
    send_line("OPEN", scmd_pkg::CHAR_LF);
    send_ticks(2);
    // new run time only applies from the next command
    configure(16'd1000, 16'd7, 16'd3);
    send_ticks(6);
    send_line("CLOSE", scmd_pkg::CHAR_CR);
    send_ticks(9);
  endtask

  task automatic test_period_lowered();
    configure(scmd_pkg::OPEN_RUN_RST, scmd_pkg::CLOSE_RUN_RST, 16'hFFFF);
    send_ticks(40);
    drain_results();
    write_reg(REG_UNUSED, 16'($urandom));
    configure(scmd_pkg::OPEN_RUN_RST, scmd_pkg::CLOSE_RUN_RST, 16'd10);
    send_ticks(3);
  endtask

  task automatic test_long_line();
    send_text("OPEN");
    repeat (126) send_item(scmd_pkg::OP_BYTE, rand_text_byte(), rand_sample());
    send_item(scmd_pkg::OP_BYTE, scmd_pkg::CHAR_CR, rand_sample());
    send_line("OPEN", scmd_pkg::CHAR_LF);
    send_ticks(2);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [15:0] open_ms, input logic [15:0] close_ms,
                                     input logic [15:0] period, input int n);
    int target;
    int r;
    configure(open_ms, close_ms, period);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 2) begin
        drain_results();
      end else if (r < 45) begin
        if ($urandom_range(1) == 0) send_line("OPEN", rand_terminator());
        else send_line("CLOSE", rand_terminator());
      end else if (r < 80) begin
        send_ticks($urandom_range(1, 8));
      end else if (r < 90) begin
        send_near_miss();
      end else begin
        send_item(scmd_pkg::op_t'($urandom_range(1)), 8'($urandom), rand_sample());
      end
    end
  endtask

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (pending_levels.size() == 0) begin
        report_mismatch("result with none pending", 16'(out_bus.command_seen), 16'd0);
      end else begin
        want_levels = pending_levels.pop_front();
        if (out_bus.motor_on !== want_levels.motor_on)
          report_mismatch("motor_on", 16'(out_bus.motor_on), 16'(want_levels.motor_on));
        if (out_bus.motor_reverse !== want_levels.motor_reverse)
          report_mismatch("motor_reverse", 16'(out_bus.motor_reverse),
                          16'(want_levels.motor_reverse));
        if (out_bus.command_seen !== want_levels.command_seen)
          report_mismatch("command_seen", 16'(out_bus.command_seen),
                          16'(want_levels.command_seen));
        if (out_bus.report_valid !== want_levels.report_valid)
          report_mismatch("report_valid", 16'(out_bus.report_valid),
                          16'(want_levels.report_valid));
        if (out_bus.sense_ma !== want_levels.sense_ma)
          report_mismatch("sense_ma", 16'(out_bus.sense_ma), 16'(want_levels.sense_ma));
        if (out_bus.led_level !== want_levels.led_level)
          report_mismatch("led_level", 16'(out_bus.led_level), 16'(want_levels.led_level));
      end
    end
  end

  // ends the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("serial_command_timed_motor_driver_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_prediction();
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.opcode <= scmd_pkg::OP_BYTE;
    in_bus.rx_byte <= '0;
    in_bus.adc_sample <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_commands();
    test_zero_settings();
    test_run_time_change();
    test_period_lowered();
    test_long_line();
    test_random_traffic(0, 0, 16'($urandom_range(30)), 16'($urandom_range(30)),
                        16'($urandom_range(1, 12)), 210);
    test_random_traffic(63, 0, 16'hFFFF, 16'd0, 16'd1, 210);
    test_random_traffic(0, 63, 16'($urandom_range(40)), 16'($urandom_range(40)),
                        16'($urandom_range(1, 20)), 210);
    test_random_traffic(35, 35, 16'd0, 16'hFFFF, 16'hFFFF, 210);
    test_random_traffic(0, 0, 16'($urandom_range(1, 25)), 16'($urandom_range(1, 25)),
                        16'($urandom_range(2, 9)), 210);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("serial_command_timed_motor_driver_test: clean");
    end else begin
      $display("serial_command_timed_motor_driver_test: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
